/* hw/rtl/sapq_pkg.sv */
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared constants, types and pointer helpers for the sorted-array priority
// queue: depth, status codes, entry layout and controller/datapath structs.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_MIN_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W      = 7;
   localparam int CNT_W       = (CNT_MIN_W > FILL_W) ? CNT_MIN_W : FILL_W;
   localparam int VALUE_W     = 32;
   localparam int PRIO_W      = 16;
   localparam int STATUS_W    = 2;

   // operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic        [PRIO_W-1:0]  prio;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch request payload
      logic ins_init;   // start insert walk from the tail
      logic shift;      // move one entry back a slot
      logic place;      // write new entry, post inserted result
      logic pop_rd;     // read head entry
      logic pop;        // drop head, post removed result
      logic set_full;   // post full result
      logic set_empty;  // post empty result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_remove;
      logic full;
      logic empty;
      logic k_one;
      logic greater;
   } dp_sts_type;

   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      ptr_inc = (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
      ptr_dec = (p == '0) ? IDX_W'(QUEUE_DEPTH - 1) : p - IDX_W'(1);
   endfunction

endpackage

/* hw/rtl/sapq_req_if.sv */
// ----------------------------------------------------------------------------
// sapq_req_if
// Request channel: valid/ready handshake carrying one queue operation.
// ----------------------------------------------------------------------------
interface sapq_req_if
   import sapq_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [VALUE_W-1:0] item_value;
   logic        [PRIO_W-1:0]  item_priority;

   modport source (output valid, output kind, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input kind, input item_value, input item_priority,
                   output ready);
endinterface

/* hw/rtl/sapq_rsp_if.sv */
// ----------------------------------------------------------------------------
// sapq_rsp_if
// Response channel: valid/ready handshake carrying one status transaction.
// ----------------------------------------------------------------------------
interface sapq_rsp_if
   import sapq_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic        [STATUS_W-1:0] status;
   logic signed [VALUE_W-1:0]  out_value;
   logic        [PRIO_W-1:0]   out_priority;
   logic        [FILL_W-1:0]   fill_count;

   modport source (output valid, output status, output out_value, output out_priority,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input out_value, input out_priority,
                   input fill_count, output ready);
endinterface

/* hw/rtl/sapq_datapath.sv */
// ----------------------------------------------------------------------------
// sapq_datapath
// Circular entry store with head/tail pointers, insert walk pointers and the
// registered response payload.
// ----------------------------------------------------------------------------
module sapq_datapath
   import sapq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_sts_type                 sts,
   input  logic                       req_kind,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic        [PRIO_W-1:0]   req_priority,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_value,
   output logic        [PRIO_W-1:0]   rsp_priority,
   output logic        [FILL_W-1:0]   rsp_fill
);

   entry_type              store_mem [QUEUE_DEPTH];
   entry_type              rd_data_ff;
   entry_type              item_ff;
   logic                   kind_ff;
   logic [IDX_W-1:0]       head_ff, tail_ff, pos_ff, prev_ff;
   logic [IDX_W-1:0]       head_in, tail_in, pos_in, prev_in;
   logic [CNT_W-1:0]       count_ff, count_in, k_ff, k_in;
   logic [IDX_W-1:0]       rd_addr;
   logic                   rd_en;
   logic                   wr_en;
   entry_type              wr_data;
   logic                   res_load;
   logic [STATUS_W-1:0]    status_ff, status_in;
   entry_type              res_ff, res_in;
   logic [FILL_W-1:0]      fill_ff;

   // read address: insert walk or head
   always_comb begin
      rd_en = cmd.ins_init | cmd.shift | cmd.pop_rd;
      priority if (cmd.ins_init) begin
         rd_addr = ptr_dec(tail_ff);
      end else if (cmd.shift) begin
         rd_addr = ptr_dec(prev_ff);
      end else begin
         rd_addr = head_ff;
      end
      wr_en   = cmd.shift | cmd.place;
      wr_data = cmd.shift ? rd_data_ff : item_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
      if (cmd.load) begin
         kind_ff       <= req_kind;
         item_ff.value <= req_value;
         item_ff.prio  <= req_priority;
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      res_load  = 1'b0;
      status_in = status_ff;
      res_in    = '0;
      if (cmd.ins_init) begin
         pos_in  = tail_ff;
         prev_in = ptr_dec(tail_ff);
         k_in    = count_ff;
      end
      if (cmd.shift) begin
         pos_in  = prev_ff;
         prev_in = ptr_dec(prev_ff);
         k_in    = k_ff - CNT_W'(1);
      end
      if (cmd.place) begin
         tail_in   = ptr_inc(tail_ff);
         count_in  = count_ff + CNT_W'(1);
         res_load  = 1'b1;
         status_in = ST_INSERTED;
      end
      if (cmd.pop) begin
         head_in   = ptr_inc(head_ff);
         count_in  = count_ff - CNT_W'(1);
         res_load  = 1'b1;
         status_in = ST_REMOVED;
         res_in    = rd_data_ff;
      end
      if (cmd.set_full) begin
         res_load  = 1'b1;
         status_in = ST_FULL;
      end
      if (cmd.set_empty) begin
         res_load  = 1'b1;
         status_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         pos_ff   <= '0;
         prev_ff  <= '0;
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         pos_ff   <= pos_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         k_ff     <= k_in;
      end
      if (res_load) begin
         status_ff <= status_in;
         res_ff    <= res_in;
         fill_ff   <= count_in[FILL_W-1:0];
      end
   end

   assign sts.is_remove = (kind_ff == KIND_REMOVE);
   assign sts.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign sts.empty     = (count_ff == '0);
   assign sts.k_one     = (k_ff == CNT_W'(1));
   assign sts.greater   = (rd_data_ff.prio > item_ff.prio);

   assign rsp_status   = status_ff;
   assign rsp_value    = res_ff.value;
   assign rsp_priority = res_ff.prio;
   assign rsp_fill     = fill_ff;

endmodule

/* hw/rtl/sapq_controller.sv */
// ----------------------------------------------------------------------------
// sapq_controller
// Sequencer for insert walk and head removal, plus response valid tracking.
// ----------------------------------------------------------------------------
module sapq_controller
   import sapq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_PLACE,
      S_POP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      res_post;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (sts.is_remove) begin
               if (sts.empty) begin
                  if (rsp_free) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_IDLE;
                  end
               end else begin
                  cmd.pop_rd = 1'b1;
                  state_in   = S_POP;
               end
            end else if (sts.full) begin
               if (rsp_free) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.ins_init = 1'b1;
               state_in     = sts.empty ? S_PLACE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.greater) begin
               cmd.shift = 1'b1;
               if (sts.k_one) begin
                  state_in = S_PLACE;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (rsp_free) begin
               cmd.place = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_POP: begin
            if (rsp_free) begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res_post     = cmd.place | cmd.pop | cmd.set_full | cmd.set_empty;
   assign rsp_valid_in = res_post ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/sorted_array_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Bounded priority queue held sorted in a circular entry store; lower
// priority number leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// sequence: the start state posts a full or empty result directly, reads the
//   head for a remove (posted from the pop state), or starts the insert walk,
//   which moves one entry back per cycle until it stops, then the place state
//   writes the new entry; posting waits while the response is still stalled
// throughput: one transaction in flight; the next request is taken the cycle
//   after the response is posted
// reset: synchronous, active high; clears pointers, count and handshake state,
//   the entry store itself is not cleared
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core
   import sapq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sapq_req_if.sink          req_ch,
   sapq_rsp_if.source        rsp_ch
);

   // command and status between sequencer and datapath
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // sequencer: accepts one request, steps the walk, owns response valid
   sapq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // datapath: entry store, pointers, count and the response payload register,
   // so a finished response can wait while the next request is taken
   sapq_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .sts          (dp_sts),
      .req_kind     (req_ch.kind),
      .req_value    (req_ch.item_value),
      .req_priority (req_ch.item_priority),
      .rsp_status   (rsp_ch.status),
      .rsp_value    (rsp_ch.out_value),
      .rsp_priority (rsp_ch.out_priority),
      .rsp_fill     (rsp_ch.fill_count)
   );

endmodule

/* hw/rtl/sapq_checker.sv */
// ----------------------------------------------------------------------------
// sapq_checker
// Port-level checks on response transactions, bound to the queue core.
// ----------------------------------------------------------------------------
module sapq_checker
   import sapq_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic        [STATUS_W-1:0] rsp_status,
   input logic signed [VALUE_W-1:0]  rsp_out_value,
   input logic        [PRIO_W-1:0]   rsp_out_priority,
   input logic        [FILL_W-1:0]   rsp_fill_count
);

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_value) && $stable(rsp_out_priority) && $stable(rsp_fill_count))
      else $error("response changed while stalled");

   // empty status carries a zero payload and zero fill
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_fill_count == '0 && rsp_out_value == '0 && rsp_out_priority == '0)
      else $error("empty response malformed");

   // full status reports the whole depth
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_fill_count == FILL_W'(QUEUE_DEPTH) && rsp_out_value == '0
         && rsp_out_priority == '0)
      else $error("full response malformed");

   // insert acknowledgement carries no entry
   a_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |->
         rsp_out_value == '0 && rsp_out_priority == '0)
      else $error("insert response carries data");

endmodule

bind sorted_array_priority_queue_core sapq_checker u_sapq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_out_value    (rsp_ch.out_value),
   .rsp_out_priority (rsp_ch.out_priority),
   .rsp_fill_count   (rsp_ch.fill_count)
);
